>>> hdl/ptc_pkg.sv
// Shared types and constants of the pressure/temperature compensation pipeline.
package ptc_pkg;

    localparam logic [2:0] REG_T1  = 3'd0;
    localparam logic [2:0] REG_T23 = 3'd1;
    localparam logic [2:0] REG_P1  = 3'd2;
    localparam logic [2:0] REG_P23 = 3'd3;
    localparam logic [2:0] REG_P45 = 3'd4;
    localparam logic [2:0] REG_P67 = 3'd5;
    localparam logic [2:0] REG_P89 = 3'd6;

    localparam logic signed [32:0] TEMP_OFFSET = 33'sd128000;
    localparam logic [20:0]        PRESS_BASE  = 21'd1048576;
    localparam logic [11:0]        NUM_SCALE   = 12'd3125;
    localparam logic [63:0]        DEN_ONE     = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_coef;

    typedef struct packed {
        logic signed [31:0] temp;
        logic signed [32:0] x;
        logic [20:0]        pn;
    } t_tmp;

    typedef struct packed {
        logic signed [31:0] temp;
        logic               dz;
        logic               neg;
        logic [63:0]        mn;
        logic [30:0]        md;
    } t_dvin;

    typedef struct packed {
        logic signed [31:0] temp;
        logic               dz;
        logic               neg;
        logic [63:0]        q;
    } t_dvout;

endpackage

>>> hdl/ptc_temp.sv
// Temperature stages: fine temperature, centidegree output, pressure offset terms.
module ptc_temp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  logic [19:0]    i_raw_t,
    input  logic [19:0]    i_raw_p,
    input  ptc_pkg::t_coef i_coef,
    output logic           o_valid,
    output ptc_pkg::t_tmp  o_data
);
    import ptc_pkg::*;

    logic [2:0] r_v;
    logic [31:0] r1_m1, r1_m2, r2_m3;
    logic signed [31:0] r2_v1, r3_fine;
    logic [19:0] r1_rp, r2_rp, r3_rp;
    t_tmp r4_d;

    logic signed [17:0] a, b;
    logic signed [33:0] m1, m2;
    logic signed [35:0] m3;
    logic signed [31:0] v1, v2, fine;
    logic [31:0] f5;
    t_tmp n4_d;

    always_comb begin
        a  = $signed({1'b0, i_raw_t[19:3]}) - $signed({1'b0, i_coef.t1, 1'b0});
        b  = $signed({2'b0, i_raw_t[19:4]}) - $signed({2'b0, i_coef.t1});
        m1 = a * i_coef.t2;
        m2 = b * b;
        v1 = $signed(r1_m1) >>> 11;
        m3 = $signed(r1_m2[31:12]) * i_coef.t3;
        v2 = $signed(r2_m3) >>> 14;
        fine = r2_v1 + v2;
        f5 = {r3_fine[29:0], 2'b00} + r3_fine + 32'd128;
        n4_d.temp = $signed(f5) >>> 8;
        n4_d.x    = $signed({r3_fine[31], r3_fine}) - TEMP_OFFSET;
        n4_d.pn   = PRESS_BASE - {1'b0, r3_rp};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_m1   <= m1[31:0];
            r1_m2   <= m2[31:0];
            r1_rp   <= i_raw_p;
            r2_v1   <= v1;
            r2_m3   <= m3[31:0];
            r2_rp   <= r1_rp;
            r3_fine <= fine;
            r3_rp   <= r2_rp;
            r4_d    <= n4_d;
        end
    end

    logic r4_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_adv) begin
            r4_v <= r_v[2];
        end
    end

    assign o_valid = r4_v;
    assign o_data  = r4_d;
endmodule

>>> hdl/ptc_front.sv
// Pressure stages ahead of the divider: numerator and divisor, 64-bit wrapping.
module ptc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  ptc_pkg::t_tmp  i_data,
    input  ptc_pkg::t_coef i_coef,
    output logic           o_valid,
    output ptc_pkg::t_dvin o_data
);
    import ptc_pkg::*;

    logic [6:0] r_v;

    // stage 5
    logic [63:0] r5_xx;
    logic signed [48:0] r5_xp5, r5_xp2;
    logic signed [31:0] r5_temp;
    logic [20:0] r5_pn;
    // stage 6
    logic signed [48:0] r6_lo6, r6_lo3, r6_xp5, r6_xp2;
    logic [31:0] r6_hi6, r6_hi3;
    logic signed [31:0] r6_temp;
    logic [20:0] r6_pn;
    // stage 7
    logic [63:0] r7_y, r7_d0;
    logic signed [48:0] r7_xp2;
    logic signed [31:0] r7_temp;
    logic [20:0] r7_pn;
    // stage 8
    logic [63:0] r8_e, r8_num;
    logic signed [31:0] r8_temp;
    // stage 9
    logic [47:0] r9_elo;
    logic [31:0] r9_ehi, r9_nhi;
    logic [43:0] r9_nlo;
    logic signed [31:0] r9_temp;
    // stage 10
    logic [30:0] r10_dd;
    logic [63:0] r10_np;
    logic signed [31:0] r10_temp;
    // stage 11
    t_dvin r11_d;

    logic signed [65:0] xx;
    logic signed [48:0] xp5, xp2, lo6, hi6, lo3, hi3;
    logic [63:0] lo6x, lo3x, xp5x, xp2x, y, d0, e, num, ep, np;
    logic [47:0] elo, ehi;
    logic [43:0] nlo, nhi;
    t_dvin n11_d;

    always_comb begin
        xx  = i_data.x * i_data.x;
        xp5 = i_data.x * i_coef.p5;
        xp2 = i_data.x * i_coef.p2;

        lo6 = $signed({1'b0, r5_xx[31:0]}) * i_coef.p6;
        hi6 = $signed({1'b0, r5_xx[63:32]}) * i_coef.p6;
        lo3 = $signed({1'b0, r5_xx[31:0]}) * i_coef.p3;
        hi3 = $signed({1'b0, r5_xx[63:32]}) * i_coef.p3;

        lo6x = {{15{r6_lo6[48]}}, r6_lo6};
        lo3x = {{15{r6_lo3[48]}}, r6_lo3};
        xp5x = {{15{r6_xp5[48]}}, r6_xp5};
        y    = lo6x + {r6_hi6, 32'b0} + {xp5x[46:0], 17'b0}
             + {{13{i_coef.p4[15]}}, i_coef.p4, 35'b0};
        d0   = lo3x + {r6_hi3, 32'b0};

        xp2x = {{15{r7_xp2[48]}}, r7_xp2};
        e    = {{8{r7_d0[63]}}, r7_d0[63:8]} + {xp2x[51:0], 12'b0} + DEN_ONE;
        num  = {12'b0, r7_pn, 31'b0} - r7_y;

        elo = r8_e[31:0] * i_coef.p1;
        ehi = r8_e[63:32] * i_coef.p1;
        nlo = r8_num[31:0] * NUM_SCALE;
        nhi = r8_num[63:32] * NUM_SCALE;

        ep = {16'b0, r9_elo} + {r9_ehi, 32'b0};
        np = {20'b0, r9_nlo} + {r9_nhi, 32'b0};

        n11_d.temp = r10_temp;
        n11_d.dz   = (r10_dd == '0);
        n11_d.neg  = r10_np[63] ^ r10_dd[30];
        n11_d.mn   = r10_np[63] ? (64'd0 - r10_np) : r10_np;
        n11_d.md   = r10_dd[30] ? (31'd0 - r10_dd) : r10_dd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r5_xx    <= xx[63:0];
            r5_xp5   <= xp5;
            r5_xp2   <= xp2;
            r5_temp  <= i_data.temp;
            r5_pn    <= i_data.pn;

            r6_lo6   <= lo6;
            r6_hi6   <= hi6[31:0];
            r6_lo3   <= lo3;
            r6_hi3   <= hi3[31:0];
            r6_xp5   <= r5_xp5;
            r6_xp2   <= r5_xp2;
            r6_temp  <= r5_temp;
            r6_pn    <= r5_pn;

            r7_y     <= y;
            r7_d0    <= d0;
            r7_xp2   <= r6_xp2;
            r7_temp  <= r6_temp;
            r7_pn    <= r6_pn;

            r8_e     <= e;
            r8_num   <= num;
            r8_temp  <= r7_temp;

            r9_elo   <= elo;
            r9_ehi   <= ehi[31:0];
            r9_nlo   <= nlo;
            r9_nhi   <= nhi[31:0];
            r9_temp  <= r8_temp;

            r10_dd   <= ep[63:33];
            r10_np   <= np;
            r10_temp <= r9_temp;

            r11_d    <= n11_d;
        end
    end

    assign o_valid = r_v[6];
    assign o_data  = r11_d;
endmodule

>>> hdl/ptc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module ptc_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  ptc_pkg::t_dvin  i_data,
    output logic            o_valid,
    output ptc_pkg::t_dvout o_data
);
    import ptc_pkg::*;

    localparam int DIV_STEPS = 64;

    typedef struct packed {
        logic signed [31:0] temp;
        logic               dz;
        logic               neg;
        logic [30:0]        md;
        logic [30:0]        rem;
        logic [63:0]        nq;
    } t_dst;

    logic [DIV_STEPS-1:0] r_v;
    t_dst r_st [DIV_STEPS];
    t_dst n_st [DIV_STEPS];

    always_comb begin
        t_dst src;
        logic [31:0] trial;
        logic ge;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                src.temp = i_data.temp;
                src.dz   = i_data.dz;
                src.neg  = i_data.neg;
                src.md   = i_data.md;
                src.rem  = '0;
                src.nq   = i_data.mn;
            end else begin
                src = r_st[k-1];
            end
            trial = {src.rem, src.nq[63]};
            ge    = (trial >= {1'b0, src.md});
            n_st[k]      = src;
            n_st[k].rem  = ge ? 31'(trial - {1'b0, src.md}) : trial[30:0];
            n_st[k].nq   = {src.nq[62:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[DIV_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_st <= n_st;
        end
    end

    assign o_valid     = r_v[DIV_STEPS-1];
    assign o_data.temp = r_st[DIV_STEPS-1].temp;
    assign o_data.dz   = r_st[DIV_STEPS-1].dz;
    assign o_data.neg  = r_st[DIV_STEPS-1].neg;
    assign o_data.q    = r_st[DIV_STEPS-1].nq;
endmodule

>>> hdl/ptc_post.sv
// Post-divide correction terms, offset, saturation and the output register.
module ptc_post (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  ptc_pkg::t_dvout i_data,
    input  ptc_pkg::t_coef  i_coef,
    output logic            o_valid,
    output logic [31:0]     o_temp,
    output logic [31:0]     o_press,
    output logic            o_dz
);
    import ptc_pkg::*;

    logic [5:0] r_v;
    logic signed [31:0] r_temp [6];
    logic [5:0] r_dz;

    logic [63:0] ra_p;
    logic [63:0] rb_s, rb_p;
    logic signed [48:0] rb_slo, rb_rlo;
    logic [31:0] rb_shi, rb_rhi;
    logic [63:0] rc_t, rc_s, rc_r, rc_p;
    logic [63:0] rd_ll, rd_r, rd_p;
    logic [31:0] rd_hl, rd_lh;
    logic [63:0] re_q, re_r, re_p;
    logic [63:0] rf_pf;

    logic [63:0] s, slox, rlox, rr, qq0, pf;
    logic signed [48:0] slo, shi, rlo, rhi;
    logic [63:0] m_ll, m_hl, m_lh;
    logic [31:0] sat;

    always_comb begin
        s   = {{13{ra_p[63]}}, ra_p[63:13]};
        slo = $signed({1'b0, s[31:0]}) * i_coef.p9;
        shi = $signed({1'b0, s[63:32]}) * i_coef.p9;
        rlo = $signed({1'b0, ra_p[31:0]}) * i_coef.p8;
        rhi = $signed({1'b0, ra_p[63:32]}) * i_coef.p8;

        slox = {{15{rb_slo[48]}}, rb_slo};
        rlox = {{15{rb_rlo[48]}}, rb_rlo};
        rr   = rlox + {rb_rhi, 32'b0};

        m_ll = rc_t[31:0] * rc_s[31:0];
        m_hl = rc_t[63:32] * rc_s[31:0];
        m_lh = rc_t[31:0] * rc_s[63:32];

        qq0 = rd_ll + {rd_hl + rd_lh, 32'b0};

        pf = re_p + re_q + re_r;
        pf = {{8{pf[63]}}, pf[63:8]} + {{44{i_coef.p7[15]}}, i_coef.p7, 4'b0};

        if (rf_pf[63] || r_dz[5]) begin
            sat = '0;
        end else if (rf_pf[63:32] != '0) begin
            sat = '1;
        end else begin
            sat = rf_pf[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            o_valid <= 1'b0;
        end else if (i_adv) begin
            r_v     <= {r_v[4:0], i_valid};
            o_valid <= r_v[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_temp[0] <= i_data.temp;
            r_dz[0]   <= i_data.dz;
            for (int k = 1; k < 6; k++) begin
                r_temp[k] <= r_temp[k-1];
                r_dz[k]   <= r_dz[k-1];
            end

            ra_p   <= i_data.neg ? (64'd0 - i_data.q) : i_data.q;

            rb_s   <= s;
            rb_p   <= ra_p;
            rb_slo <= slo;
            rb_shi <= shi[31:0];
            rb_rlo <= rlo;
            rb_rhi <= rhi[31:0];

            rc_t   <= slox + {rb_shi, 32'b0};
            rc_s   <= rb_s;
            rc_r   <= {{19{rr[63]}}, rr[63:19]};
            rc_p   <= rb_p;

            rd_ll  <= m_ll;
            rd_hl  <= m_hl[31:0];
            rd_lh  <= m_lh[31:0];
            rd_r   <= rc_r;
            rd_p   <= rc_p;

            re_q   <= {{25{qq0[63]}}, qq0[63:25]};
            re_r   <= rd_r;
            re_p   <= rd_p;

            rf_pf  <= pf;

            o_temp  <= r_temp[5];
            o_press <= sat;
            o_dz    <= r_dz[5];
        end
    end
endmodule

>>> hdl/pressure_temperature_compensation_unit.sv
// Top level of the barometric pressure/temperature compensation pipeline.
//
// Usage:
//   Input channel: i_valid / o_stall carry one item (raw 20-bit temperature and
//   raw 20-bit pressure). An item is taken on a clock edge with i_valid high and
//   o_stall low. Output channel: o_valid / i_stall carry one result item per
//   input item: temperature in 0.01 degC, pressure in Pa as Q24.8 (saturated to
//   the unsigned 32-bit range) and a flag that marks a zero pressure divisor.
//   Calibration: seven packed coefficient registers written over i_cfg_we,
//   i_cfg_idx, i_cfg_data; write them only while the pipeline is empty.
// Throughput: one item per cycle unless the pipeline is stalled. Stages: the
//   64-stage divider (one quotient bit per stage) plus the 18 multiply/add
//   stages around it.
// Stall: the whole pipeline holds while o_valid is high and i_stall is set, and
//   o_stall follows that same condition; nothing is dropped or repeated.
// Reset: synchronous, active low; clears all valid bits and the coefficient
//   registers. With all-zero coefficients the divisor is zero, so results carry
//   pressure 0 with the zero-divisor flag set.
module pressure_temperature_compensation_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [19:0]        i_raw_temperature,
    input  logic [19:0]        i_raw_pressure,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_temperature_centi,
    output logic [31:0]        o_pressure_q24_8,
    output logic               o_divisor_zero,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    import ptc_pkg::*;

    logic [15:0] r_t1, r_p1;
    logic [31:0] r_t23, r_p23, r_p45, r_p67, r_p89;
    t_coef coef;

    logic   adv;
    logic   tmp_valid, frt_valid, div_valid;
    t_tmp   tmp_data;
    t_dvin  frt_data;
    t_dvout div_data;
    logic [31:0] temp_bits;

    // Calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1  <= '0;
            r_t23 <= '0;
            r_p1  <= '0;
            r_p23 <= '0;
            r_p45 <= '0;
            r_p67 <= '0;
            r_p89 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_T1:  r_t1  <= i_cfg_data[15:0];
                REG_T23: r_t23 <= i_cfg_data;
                REG_P1:  r_p1  <= i_cfg_data[15:0];
                REG_P23: r_p23 <= i_cfg_data;
                REG_P45: r_p45 <= i_cfg_data;
                REG_P67: r_p67 <= i_cfg_data;
                REG_P89: r_p89 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Lower-numbered coefficient sits in the low half
    always_comb begin
        coef.t1 = r_t1;
        coef.t2 = r_t23[15:0];
        coef.t3 = r_t23[31:16];
        coef.p1 = r_p1;
        coef.p2 = r_p23[15:0];
        coef.p3 = r_p23[31:16];
        coef.p4 = r_p45[15:0];
        coef.p5 = r_p45[31:16];
        coef.p6 = r_p67[15:0];
        coef.p7 = r_p67[31:16];
        coef.p8 = r_p89[15:0];
        coef.p9 = r_p89[31:16];
    end

    // Global advance: every stage moves unless a result is held at the output
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    ptc_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_raw_t (i_raw_temperature),
        .i_raw_p (i_raw_pressure),
        .i_coef  (coef),
        .o_valid (tmp_valid),
        .o_data  (tmp_data)
    );

    ptc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (tmp_valid),
        .i_data  (tmp_data),
        .i_coef  (coef),
        .o_valid (frt_valid),
        .o_data  (frt_data)
    );

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (frt_valid),
        .i_data  (frt_data),
        .o_valid (div_valid),
        .o_data  (div_data)
    );

    ptc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (div_valid),
        .i_data  (div_data),
        .i_coef  (coef),
        .o_valid (o_valid),
        .o_temp  (temp_bits),
        .o_press (o_pressure_q24_8),
        .o_dz    (o_divisor_zero)
    );

    assign o_temperature_centi = $signed(temp_bits);
endmodule

>>> verif/tb.sv
// Self-checking testbench for the pressure/temperature compensation pipeline.
`timescale 1ns / 1ps

module tb;
    import ptc_pkg::*;

    // one result item of the block
    typedef struct {
        logic signed [31:0] temp;
        logic [31:0]        press;
        logic               dz;
    } t_comp_result;

    // Scoreboard: holds the calibration copy, predicts each accepted item and
    // checks results in order.
    class comp_scoreboard;
        logic [31:0]  cal[7];
        t_comp_result pending[$];
        int           errors;

        function new();
            foreach (cal[i]) cal[i] = '0;
            errors = 0;
        endfunction

        function void write_cal(logic [2:0] idx, logic [31:0] val);
            if (idx <= REG_P89)
                cal[idx] = (idx == REG_T1 || idx == REG_P1) ? {16'h0, val[15:0]} : val;
        endfunction

        function automatic logic signed [63:0] coef(logic [2:0] idx, bit hi);
            logic [15:0] h;
            h = hi ? cal[idx][31:16] : cal[idx][15:0];
            return {{48{h[15]}}, h};
        endfunction

        // fixed-point compensation, both paths
        function automatic t_comp_result compensate(logic [19:0] rt, logic [19:0] rp);
            t_comp_result res;
            logic signed [31:0] t1, t2, t3, a, b, v1, v2, fine, tmp32;
            logic signed [63:0] p1, x, y, d, p, q, r, n;
            logic [63:0] mn, md, qu;
            t1 = {16'h0, cal[REG_T1][15:0]};
            t2 = {{16{cal[REG_T23][15]}}, cal[REG_T23][15:0]};
            t3 = {{16{cal[REG_T23][31]}}, cal[REG_T23][31:16]};
            a = {15'h0, rt[19:3]} - (t1 << 1);
            v1 = (a * t2) >>> 11;
            b = {16'h0, rt[19:4]} - t1;
            tmp32 = (b * b) >>> 12;
            v2 = (tmp32 * t3) >>> 14;
            fine = v1 + v2;
            tmp32 = fine * 32'sd5 + 32'sd128;
            res.temp = tmp32 >>> 8;

            p1 = {48'h0, cal[REG_P1][15:0]};
            x = {{32{fine[31]}}, fine} - 64'sd128000;
            y = x * x * coef(REG_P67, 0);
            y += (x * coef(REG_P45, 1)) << 17;
            y += coef(REG_P45, 0) << 35;
            d = ((x * x * coef(REG_P23, 1)) >>> 8) + ((x * coef(REG_P23, 0)) << 12);
            d = (((64'sd1 << 47) + d) * p1) >>> 33;
            res.press = '0;
            res.dz = 1'b0;
            if (d == 0) begin
                res.dz = 1'b1;
            end else begin
                p = 64'sd1048576 - {44'h0, rp};
                n = ((p << 31) - y) * 64'sd3125;
                mn = n[63] ? -n : n;
                md = d[63] ? -d : d;
                qu = mn / md;
                p = (n[63] != d[63]) ? -qu : qu;
                q = (coef(REG_P89, 1) * (p >>> 13) * (p >>> 13)) >>> 25;
                r = (coef(REG_P89, 0) * p) >>> 19;
                p = ((p + q + r) >>> 8) + (coef(REG_P67, 1) << 4);
                if (p[63])
                    res.press = '0;
                else if (p > 64'sd4294967295)
                    res.press = 32'hFFFF_FFFF;
                else
                    res.press = p[31:0];
            end
            return res;
        endfunction

        function void note_item(logic [19:0] rt, logic [19:0] rp);
            pending.push_back(compensate(rt, rp));
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
            errors++;
        endtask

        task check_result(logic signed [31:0] temp, logic [31:0] press, logic dz);
            t_comp_result e;
            if (pending.size() == 0) begin
                report("unexpected result item", 64'(press), 0);
                return;
            end
            e = pending.pop_front();
            if (temp !== e.temp) report("temperature_centi", 64'(temp), 64'(e.temp));
            if (press !== e.press) report("pressure_q24_8", 64'(press), 64'(e.press));
            if (dz !== e.dz) report("divisor_zero", 64'(dz), 64'(e.dz));
        endtask
    endclass

    localparam int LATENCY = 82;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [19:0]        i_raw_temperature = '0;
    logic [19:0]        i_raw_pressure = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_temperature_centi;
    logic [31:0]        o_pressure_q24_8;
    logic               o_divisor_zero;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;

    comp_scoreboard sb = new();
    bit  hold_off = 1'b0;   // long receiver hold-off requested by stimulus
    int  burst_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    pressure_temperature_compensation_unit DUT (.*);

    // Output side: check every accepted result item.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_temperature_centi, o_pressure_q24_8, o_divisor_zero);
    end

    // Receiver stall pattern: phases of free flow, light and heavy stalling,
    // plus a long hold-off on request.
    initial begin
        int mode, len;
        forever begin
            mode = $urandom_range(0, 2);
            len = $urandom_range(10, 120);
            repeat (len) begin
                @(posedge i_clk);
                if (hold_off)
                    i_stall <= 1'b1;
                else if (mode == 0)
                    i_stall <= 1'b0;
                else if (mode == 1)
                    i_stall <= ($urandom_range(0, 3) == 0);
                else
                    i_stall <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Send one item; keeps valid high across bursts, gaps between them.
    task send_item(logic [19:0] rt, logic [19:0] rp);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        i_valid <= 1'b1;
        i_raw_temperature <= rt;
        i_raw_pressure <= rp;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(rt, rp);
        burst_left--;
    endtask

    task drain();
        int guard;
        i_valid <= 1'b0;
        burst_left = 0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_cal(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // nominal factory-like calibration with a random spread
    task load_typical();
        write_reg(REG_T1, 32'($urandom_range(26000, 29000)));
        write_reg(REG_T23, {16'($signed(-$urandom_range(0, 2000))),
                            16'($urandom_range(25000, 27500))});
        write_reg(REG_P1, 32'($urandom_range(35000, 38500)));
        write_reg(REG_P23, {16'($urandom_range(2000, 3000)),
                            16'($signed(-$urandom_range(10000, 11000)))});
        write_reg(REG_P45, {16'($signed(-$urandom_range(0, 200))),
                            16'($urandom_range(7000, 9000))});
        write_reg(REG_P67, {16'($urandom_range(12000, 16000)),
                            16'($signed(-$urandom_range(0, 10)))});
        write_reg(REG_P89, {16'($urandom_range(5000, 7000)),
                            16'($signed(-$urandom_range(10000, 15000)))});
    endtask

    task load_random();
        for (int i = 0; i <= REG_P89; i++) write_reg(3'(i), $urandom);
    endtask

    task send_random(int n, bit sensible);
        repeat (n) begin
            if (sensible)
                send_item(20'($urandom_range(400000, 600000)),
                          20'($urandom_range(250000, 450000)));
            else
                send_item(20'($urandom), 20'($urandom));
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: zero divisor everywhere, extremes of the raw fields
        send_item(20'h00000, 20'h00000);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'h55555, 20'hAAAAA);
        drain();

        // extreme register values, incl. write to an index past the list
        for (int i = 0; i <= REG_P89; i++) write_reg(3'(i), 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h1234_5678);
        send_item(20'h00000, 20'h00000);
        send_item(20'hFFFFF, 20'hFFFFF);
        send_item(20'hFFFFF, 20'h00000);
        send_item(20'h80000, 20'h7FFFF);
        drain();
        for (int i = 0; i <= REG_P89; i++) write_reg(3'(i), 32'h8000_7FFF);
        send_item(20'h00000, 20'hFFFFF);
        send_item(20'hFFFFF, 20'h00000);
        send_item(20'h12345, 20'h6789A);
        drain();

        // typical calibration: saturation at both ends, normal readings
        load_typical();
        send_item(20'd519888, 20'd415148);
        send_item(20'd519888, 20'h00000);
        send_item(20'd519888, 20'hFFFFF);
        send_item(20'h00000, 20'd415148);
        send_item(20'hFFFFF, 20'd415148);
        // receiver holds off while input keeps coming: the pipeline fills
        fork
            begin
                hold_off = 1'b1;
                repeat (150) @(posedge i_clk);
                hold_off = 1'b0;
            end
            send_random(120, 1);
        join
        drain();   // sender pause until all results are back

        // random phases with several calibration settings
        for (int ph = 0; ph < 10; ph++) begin
            if (ph % 3 == 2) load_random(); else load_typical();
            send_random(120, 1);
            send_random(40, 0);
            drain();
        end
        for (int i = 0; i <= REG_P89; i++) write_reg(3'(i), 32'h0);
        send_random(30, 0);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> files.f
hdl/ptc_pkg.sv
hdl/ptc_temp.sv
hdl/ptc_front.sv
hdl/ptc_div.sv
hdl/ptc_post.sv
hdl/pressure_temperature_compensation_unit.sv
verif/tb.sv
